// ===== rtl/core/kflvt_pkg.sv =====
package kflvt_pkg;

  localparam int POSE_WORDS = 6;

  // input function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XFORM = 1'b1;

  // pose table select
  localparam logic FRAME_CUR = 1'b0;
  localparam logic FRAME_NXT = 1'b1;

  // configuration register indexes
  localparam logic CFG_FRACTION = 1'b0;
  localparam logic CFG_BONES    = 1'b1;

  localparam logic [16:0] FRAC_ONE     = 17'd65536;
  localparam logic [8:0]  BONES_RESET  = 9'd256;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;
  localparam logic [14:0] QUAD_SPAN    = 15'd16384;
  localparam logic [12:0] SIN_K3       = 13'd4640;
  localparam logic [15:0] SIN_K2       = 16'd42048;
  localparam logic [16:0] SIN_K1       = 17'd102944;

  typedef struct packed {
    logic               func;
    logic [7:0]         bone_index;
    logic               frame_select;
    logic [2:0]         pose_field;
    logic signed [31:0] pose_value;
    logic signed [31:0] coord_y_in;
    logic signed [31:0] coord_z_in;
    logic signed [31:0] coord_x_in;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] coord_y_out;
    logic signed [31:0] coord_z_out;
    logic signed [31:0] coord_x_out;
    logic               bone_fault;
  } out_word_t;

  // floor((a +/- b) / 65536), kept to 36 bits
  function automatic logic signed [35:0] rot_q16(input logic signed [53:0] a,
                                                 input logic signed [53:0] b,
                                                 input logic sub);
    logic signed [54:0] s;
    s = sub ? (55'(a) - 55'(b)) : (55'(a) + 55'(b));
    return $signed(s[51:16]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/kflvt_sin.sv =====
module kflvt_sin import kflvt_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        ang,
  output logic signed [17:0] sin_o
);

  logic [1:0]  quad_a_r, quad_b_r, quad_c_r;
  logic [16:0] z_a_r, z_b_r, z_c_r;
  logic [16:0] z2_a_r, z2_b_r;
  logic [15:0] t1_r;
  logic [16:0] t2_r;
  logic signed [17:0] sin_r;

  logic [14:0] rem;
  logic [16:0] z;
  logic [33:0] zz;
  logic [29:0] m3;
  logic [32:0] m2;
  logic [33:0] m1;

  always_comb begin
    rem = ang[14] ? (QUAD_SPAN - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    z   = {rem, 2'b00};
    zz  = 34'(z) * 34'(z);
    m3  = 30'(SIN_K3) * 30'(z2_a_r);
    m2  = 33'(z2_b_r) * 33'(t1_r);
    m1  = 34'(z_c_r) * 34'(t2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad_a_r <= ang[15:14];
      z_a_r    <= z;
      z2_a_r   <= zz[32:16];

      quad_b_r <= quad_a_r;
      z_b_r    <= z_a_r;
      z2_b_r   <= z2_a_r;
      t1_r     <= SIN_K2 - {2'b00, m3[29:16]};

      quad_c_r <= quad_b_r;
      z_c_r    <= z_b_r;
      t2_r     <= SIN_K1 - m2[32:16];

      sin_r    <= quad_c_r[1] ? -$signed({1'b0, m1[32:16]}) : $signed({1'b0, m1[32:16]});
    end
  end

  assign sin_o = sin_r;

endmodule

// ===== rtl/core/keyframe_lerp_vertex_transform_top.sv =====
// An accepted transform word runs down vld_r to the output register and out_valid.
// Throughput: one word per cycle while in_ready is high, pose writes and
// transforms alike; the pose tables are two 1R1W row memories, one row per bone.
// Stall: a skid stage behind the output register keeps in_ready up for one stall.
// Reset: clears pipeline valids, interp_fraction (0) and bone_count (256);
// pose tables are not cleared.
module keyframe_lerp_vertex_transform_top import kflvt_pkg::*; #(
  parameter int BONE_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int DEPTH = (BONE_SLOTS < 256) ? BONE_SLOTS : 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [16:0] frac_r;
  logic [8:0]  bones_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r  <= 17'd0;
      bones_r <= BONES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRACTION: frac_r  <= cfg_data;
        CFG_BONES:    bones_r <= cfg_data[8:0];
      endcase
    end
  end

  logic [16:0] frac_sat;
  assign frac_sat = (frac_r > FRAC_ONE) ? FRAC_ONE : frac_r;

  // handshake
  logic en, acc, acc_x, wr_ok, flt_in, skid_vld_r, out_vld_r;
  logic [AW-1:0] addr;

  assign en       = !skid_vld_r;
  assign in_ready = en;
  assign acc      = in_valid && in_ready;
  assign acc_x    = acc && (in_data.func == FUNC_XFORM);
  assign addr     = AW'(in_data.bone_index);
  assign wr_ok    = acc && (in_data.func == FUNC_WRITE)
                    && (in_data.pose_field < 3'(POSE_WORDS))
                    && (17'(in_data.bone_index) < 17'(BONE_SLOTS));
  assign flt_in   = ({1'b0, in_data.bone_index} >= bones_r)
                    || (17'(in_data.bone_index) >= 17'(BONE_SLOTS));

  // pose memories, one row of six words per bone
  logic [POSE_WORDS-1:0][31:0] mem_cur [DEPTH];
  logic [POSE_WORDS-1:0][31:0] mem_nxt [DEPTH];
  logic [POSE_WORDS-1:0][31:0] rd_cur_r, rd_nxt_r;

  always_ff @(posedge clk) begin
    if (wr_ok && (in_data.frame_select == FRAME_CUR)) begin
      mem_cur[addr][in_data.pose_field] <= in_data.pose_value;
    end
    if (wr_ok && (in_data.frame_select == FRAME_NXT)) begin
      mem_nxt[addr][in_data.pose_field] <= in_data.pose_value;
    end
    if (acc) begin
      rd_cur_r <= mem_cur[addr];
      rd_nxt_r <= mem_nxt[addr];
    end
  end

  // control and point delay lines
  logic [13:1] vld_r, flt_r;
  logic signed [31:0] py_r [1:9];
  logic signed [31:0] pz_r [1:9];
  logic signed [31:0] px_r [1:9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[12:1], acc_x};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flt_r    <= {flt_r[12:1], flt_in};
      py_r[1]  <= in_data.coord_y_in;
      pz_r[1]  <= in_data.coord_z_in;
      px_r[1]  <= in_data.coord_x_in;
      for (int k = 2; k <= 9; k++) begin
        py_r[k] <= py_r[k-1];
        pz_r[k] <= pz_r[k-1];
        px_r[k] <= px_r[k-1];
      end
    end
  end

  // blend
  logic signed [31:0] cur_r  [POSE_WORDS];
  logic signed [50:0] prod_r [POSE_WORDS];
  logic signed [31:0] pose_r [POSE_WORDS];
  logic signed [32:0] diff   [POSE_WORDS];
  logic signed [34:0] bsum   [POSE_WORDS];

  always_comb begin
    for (int k = 0; k < POSE_WORDS; k++) begin
      diff[k] = $signed({rd_nxt_r[k][31], rd_nxt_r[k]})
                - $signed({rd_cur_r[k][31], rd_cur_r[k]});
      bsum[k] = 35'(cur_r[k]) + $signed(prod_r[k][50:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < POSE_WORDS; k++) begin
        cur_r[k]  <= $signed(rd_cur_r[k]);
        prod_r[k] <= 51'(diff[k]) * 51'($signed({1'b0, frac_sat}));
        pose_r[k] <= bsum[k][31:0];
      end
    end
  end

  // sine and cosine of the three blended angles
  logic signed [17:0] sn_w [3];
  logic signed [17:0] cs_w [3];

  for (genvar g = 0; g < 3; g++) begin : g_trig
    kflvt_sin u_sin (
      .clk   (clk),
      .en    (en),
      .ang   (pose_r[g][15:0]),
      .sin_o (sn_w[g])
    );
    kflvt_sin u_cos (
      .clk   (clk),
      .en    (en),
      .ang   (pose_r[g][15:0] + QUARTER_TURN),
      .sin_o (cs_w[g])
    );
  end

  logic signed [17:0] sn_r [8:11][3];
  logic signed [17:0] cs_r [8:11][3];
  logic signed [31:0] sh_r [4:13][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sn_r[8][j] <= sn_w[j];
        cs_r[8][j] <= cs_w[j];
        sh_r[4][j] <= pose_r[3+j];
      end
      for (int k = 9; k <= 11; k++) begin
        sn_r[k] <= sn_r[k-1];
        cs_r[k] <= cs_r[k-1];
      end
      for (int k = 5; k <= 13; k++) begin
        sh_r[k] <= sh_r[k-1];
      end
    end
  end

  // rotations: products in one stage, sum and floor shift in the next
  logic signed [53:0] p8_r [4];
  logic signed [53:0] p10_r [4];
  logic signed [53:0] p12_r [4];
  logic signed [35:0] y9_r, z9_r, y10_r, y11_r, x11_r, z11_r, z12_r, z13_r;
  logic signed [35:0] x13_r, y13_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // about x
      p8_r[0] <= 54'(cs_w[0]) * 54'(py_r[7]);
      p8_r[1] <= 54'(sn_w[0]) * 54'(pz_r[7]);
      p8_r[2] <= 54'(sn_w[0]) * 54'(py_r[7]);
      p8_r[3] <= 54'(cs_w[0]) * 54'(pz_r[7]);
      y9_r    <= rot_q16(p8_r[0], p8_r[1], 1'b1);
      z9_r    <= rot_q16(p8_r[2], p8_r[3], 1'b0);
      // about y
      p10_r[0] <= 54'(cs_r[9][1]) * 54'(px_r[9]);
      p10_r[1] <= 54'(sn_r[9][1]) * 54'(z9_r);
      p10_r[2] <= 54'(cs_r[9][1]) * 54'(z9_r);
      p10_r[3] <= 54'(sn_r[9][1]) * 54'(px_r[9]);
      y10_r    <= y9_r;
      x11_r    <= rot_q16(p10_r[0], p10_r[1], 1'b0);
      z11_r    <= rot_q16(p10_r[2], p10_r[3], 1'b1);
      y11_r    <= y10_r;
      // about z
      p12_r[0] <= 54'(cs_r[11][2]) * 54'(x11_r);
      p12_r[1] <= 54'(sn_r[11][2]) * 54'(y11_r);
      p12_r[2] <= 54'(sn_r[11][2]) * 54'(x11_r);
      p12_r[3] <= 54'(cs_r[11][2]) * 54'(y11_r);
      z12_r    <= z11_r;
      x13_r    <= rot_q16(p12_r[0], p12_r[1], 1'b1);
      y13_r    <= rot_q16(p12_r[2], p12_r[3], 1'b0);
      z13_r    <= z12_r;
    end
  end

  // shift, saturate, fault
  out_word_t res;

  always_comb begin
    if (flt_r[13]) begin
      res = '{coord_y_out: '0, coord_z_out: '0, coord_x_out: '0, bone_fault: 1'b1};
    end else begin
      res.coord_y_out = sat32(37'(y13_r) + 37'(sh_r[13][1]));
      res.coord_z_out = sat32(37'(z13_r) + 37'(sh_r[13][2]));
      res.coord_x_out = sat32(37'(x13_r) + 37'(sh_r[13][0]));
      res.bone_fault  = 1'b0;
    end
  end

  // output register plus skid word
  out_word_t out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      priority if (skid_vld_r) begin
        if (out_ready) begin
          skid_vld_r <= 1'b0;
        end
      end else if (vld_r[13]) begin
        if (out_vld_r && !out_ready) begin
          skid_vld_r <= 1'b1;
        end
        out_vld_r <= 1'b1;
      end else begin
        if (out_ready) begin
          out_vld_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (vld_r[13]) begin
      if (out_vld_r && !out_ready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/kflvt_chk.sv =====
module kflvt_chk import kflvt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input out_word_t   out_data
);

  // nothing leaves straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a faulted bone gives a zero point
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bone_fault |->
      out_data.coord_x_out == 32'sd0 && out_data.coord_y_out == 32'sd0
      && out_data.coord_z_out == 32'sd0)
    else $error("faulted word carries coordinates");

  // with no word waiting the skid is empty, so input is taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word dropped or changed while stalled");

endmodule

bind keyframe_lerp_vertex_transform_top kflvt_chk u_kflvt_chk (.*);
